// File: rtl/dimmer_level_ramp_unit_macros.svh
// Assertion macros shared by the dimmer ramp modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef DIMMER_LEVEL_RAMP_UNIT_MACROS_SVH
`define DIMMER_LEVEL_RAMP_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DLR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dimmer ramp assertion failed");

// Next-cycle implication, checked outside reset.
`define DLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dimmer ramp assertion failed");

`endif

// File: rtl/dlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dlr_pkg;

    // Full-scale lamp level and the base of the step delay division.
    localparam int FULL_LEVEL = 200;
    localparam int STEP_BASE  = 100;

    localparam int LVL_W = 8;
    localparam int DLY_W = 7;
    localparam int SQ_W  = 2 * LVL_W;

    // The restoring divider makes one quotient bit per cycle.
    localparam int DIV_STEPS = DLY_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // level*level / FULL_LEVEL is done as a multiply by a rounded-up
    // reciprocal; the shift is wide enough that the truncated result is exact.
    localparam int SQ_SHIFT  = 25;
    localparam int RECIP_INT = ((1 << SQ_SHIFT) + FULL_LEVEL - 1) / FULL_LEVEL;
    localparam int RECIP_W   = 20;
    localparam int PROD_W    = SQ_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP       = RECIP_W'(RECIP_INT);
    localparam logic [LVL_W-1:0]   FULL_L      = LVL_W'(FULL_LEVEL);
    localparam logic [DLY_W-1:0]   STEP_BASE_D = DLY_W'(STEP_BASE);

    // Register reset values.
    localparam logic [LVL_W-1:0] DIM_STEP_RST = 8'd5;
    localparam logic [LVL_W-1:0] MAX_LVL_RST  = 8'd200;

    // Command codes of the kind field.
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_SET    = 3'd1;
    localparam logic [2:0] KIND_UP     = 3'd2;
    localparam logic [2:0] KIND_DOWN   = 3'd3;
    localparam logic [2:0] KIND_TOGGLE = 3'd4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_QUAD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INHIBIT  = 3'd4;

    typedef struct packed {
        logic [2:0]       kind;
        logic [LVL_W-1:0] new_level;
    } t_in_word;

    typedef struct packed {
        logic [LVL_W-1:0] drive_level;
        logic             drive_update;
        logic [LVL_W-1:0] current_level;
        logic [LVL_W-1:0] target_level;
        logic             rejected;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DLY,
        S_SQ,
        S_SCALE,
        S_DRV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic div_step;
        logic div_end;
        logic square;
        logic scale;
        logic drive;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic dim_ok;
        logic stepped;
        logic quad;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/dlr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "dimmer_level_ramp_unit_macros.svh"

module dlr_ctrl
    import dlr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.dim_ok) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else if (i_status.stepped && i_status.quad) begin
                    n_state = S_SQ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DLY;
                end
            end
            S_DLY: begin
                o_cmd.div_end = 1'b1;
                n_state       = S_DONE;
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_state      = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_DRV;
            end
            S_DRV: begin
                o_cmd.drive = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The divider runs exactly its bit count before the delay is written.
    `DLR_ASSERT_NEXT(a_div_len, r_state == S_DIV && r_cnt == CNT_LAST, r_state == S_DLY)
    // A dim command that is not inhibited always goes through the divider.
    `DLR_ASSERT_NEXT(a_dim_divides, r_state == S_EXEC && i_status.dim_ok, r_state == S_DIV)

endmodule

`default_nettype wire

// File: rtl/dlr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

`include "dimmer_level_ramp_unit_macros.svh"

module dlr_dp
    import dlr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LVL_W-1:0]     i_cfg_data,
    input  wire t_in_word             i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_word,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status
);

    function automatic logic [LVL_W-1:0] clamp_full(input logic [LVL_W:0] v);
        return (v > (LVL_W+1)'(FULL_LEVEL)) ? FULL_L : v[LVL_W-1:0];
    endfunction

    // Configuration registers.
    logic             r_quad;
    logic [LVL_W-1:0] r_dim_step;
    logic [LVL_W-1:0] r_min;
    logic [LVL_W-1:0] r_max;
    logic             r_inhibit;

    // Ramp state.
    logic [LVL_W-1:0] r_level;
    logic [LVL_W-1:0] r_goal;
    logic [DLY_W-1:0] r_delay;
    logic [DLY_W-1:0] r_ticks;
    logic [LVL_W-1:0] r_last_drive;

    // Item and work registers.
    logic [2:0]        r_kind;
    logic [LVL_W-1:0]  r_req;
    logic              r_update;
    logic              r_rej;
    logic [LVL_W-1:0]  r_rem;
    logic [DLY_W-1:0]  r_quo;
    logic [DLY_W-1:0]  r_dvd;
    logic [SQ_W-1:0]   r_sq;
    logic [PROD_W-1:0] r_prod;
    logic              r_out_valid;
    t_out_word         r_out;

    logic [DLY_W-1:0] tick_dec;
    logic             is_dim;
    logic             stepped;
    logic [LVL_W-1:0] level_next;
    logic [LVL_W:0]   sum_up;
    logic [LVL_W:0]   sum_floor;
    logic [LVL_W:0]   rem_sh;
    logic             rem_ge;
    logic [LVL_W-1:0] drv_q;

    assign tick_dec   = (r_ticks != '0) ? r_ticks - 1'b1 : r_ticks;
    assign is_dim     = (r_kind == KIND_UP) || (r_kind == KIND_DOWN);
    assign stepped    = (r_kind == KIND_TICK) && (r_level != r_goal) && (tick_dec == '0);
    assign level_next = (r_level < r_goal) ? r_level + 1'b1 : r_level - 1'b1;
    assign sum_up     = {1'b0, r_level} + {1'b0, r_dim_step};
    assign sum_floor  = {1'b0, r_min} + {1'b0, r_dim_step};

    assign rem_sh = {r_rem, r_dvd[DLY_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_dim_step};

    assign drv_q = r_prod[SQ_SHIFT +: LVL_W];

    assign o_status.dim_ok   = is_dim && !r_inhibit;
    assign o_status.stepped  = stepped;
    assign o_status.quad     = r_quad;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad     <= 1'b0;
            r_dim_step <= DIM_STEP_RST;
            r_min      <= '0;
            r_max      <= MAX_LVL_RST;
            r_inhibit  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_QUAD:     r_quad     <= i_cfg_data[0];
                REG_DIM_STEP: r_dim_step <= i_cfg_data;
                REG_MIN:      r_min      <= i_cfg_data;
                REG_MAX:      r_max      <= i_cfg_data;
                REG_INHIBIT:  r_inhibit  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level      <= '0;
            r_goal       <= '0;
            r_delay      <= '0;
            r_ticks      <= '0;
            r_last_drive <= '0;
        end else begin
            if (i_cmd.exec) begin
                case (r_kind)
                    KIND_TICK: begin
                        if (stepped) begin
                            r_level <= level_next;
                            r_ticks <= r_delay;
                            if (!r_quad) begin
                                r_last_drive <= level_next;
                            end
                        end else begin
                            r_ticks <= tick_dec;
                        end
                    end
                    KIND_SET: begin
                        r_goal <= clamp_full({1'b0, r_req});
                    end
                    KIND_UP: begin
                        if (!r_inhibit) begin
                            if (sum_up < {1'b0, r_max}) begin
                                r_goal <= clamp_full(sum_up);
                            end else begin
                                r_goal <= clamp_full({1'b0, r_max});
                            end
                        end
                    end
                    KIND_DOWN: begin
                        if (!r_inhibit) begin
                            if ({1'b0, r_level} > sum_floor) begin
                                r_goal <= clamp_full({1'b0, r_level - r_dim_step});
                            end else begin
                                r_goal <= clamp_full({1'b0, r_min});
                            end
                        end
                    end
                    KIND_TOGGLE: begin
                        if (!r_inhibit) begin
                            r_goal <= (r_level != '0) ? '0 : FULL_L;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.div_end) begin
                r_delay <= (r_dim_step == '0) ? STEP_BASE_D : r_quo;
            end
            if (i_cmd.drive) begin
                r_last_drive <= (r_level != '0 && drv_q == '0) ? LVL_W'(1) : drv_q;
            end
        end
    end

    // Item registers, divider, squarer and scaling multiplier.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind <= i_in_word.kind;
            r_req  <= i_in_word.new_level;
        end
        if (i_cmd.exec) begin
            r_update <= stepped;
            r_rej    <= r_inhibit && (is_dim || r_kind == KIND_TOGGLE);
            r_rem    <= '0;
            r_quo    <= '0;
            r_dvd    <= STEP_BASE_D;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? LVL_W'(rem_sh - {1'b0, r_dim_step}) : rem_sh[LVL_W-1:0];
            r_quo <= {r_quo[DLY_W-2:0], rem_ge};
            r_dvd <= {r_dvd[DLY_W-2:0], 1'b0};
        end
        if (i_cmd.square) begin
            r_sq <= {{LVL_W{1'b0}}, r_level} * {{LVL_W{1'b0}}, r_level};
        end
        if (i_cmd.scale) begin
            r_prod <= {{RECIP_W{1'b0}}, r_sq} * {{SQ_W{1'b0}}, RECIP};
        end
    end

    // Output register: holds a finished word until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.drive_level   <= r_last_drive;
            r_out.drive_update  <= r_update;
            r_out.current_level <= r_level;
            r_out.target_level  <= r_goal;
            r_out.rejected      <= r_rej;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // The level and target never leave the full-scale range.
    `DLR_ASSERT_NOW(a_level_rng, 1'b1, r_level <= FULL_L)
    `DLR_ASSERT_NOW(a_goal_rng, 1'b1, r_goal <= FULL_L)
    // A new word is only loaded when the previous one is gone or leaving.
    `DLR_ASSERT_NOW(a_no_overwrite, i_cmd.out_load, !r_out_valid || !i_out_stall)

endmodule

`default_nettype wire

// File: rtl/dimmer_level_ramp_unit.sv
// Each word is latched in IDLE, run in EXEC and loaded into the output register in DONE. A tick
// that steps on the quadratic curve passes SQ, SCALE and DRV (square, reciprocal scale, drive),
// a dim command runs the restoring divider in DIV and writes the delay in DLY, and set, toggle,
// rejected, spare and all other ticks go from EXEC to DONE. Words go one at a time: the next
// word is taken in the cycle after the result enters the output register. Reset (i_rst_n low,
// synchronous) clears levels, delay, countdown and drive, and loads defaults (step 5, max 200).
`timescale 1ns / 1ps
`default_nettype none

module dimmer_level_ramp_unit
    import dlr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    // Configuration write port.
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LVL_W-1:0]     i_cfg_data,

    // Command words in.
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_word             i_in_word,

    // Result words out.
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_word                 o_out_word
);

    // The controller sequences each word: it latches the command, runs the
    // state update, then, when needed, the step-delay divider or the
    // quadratic drive mapping, and finally hands the result to the output
    // register. The datapath holds the data registers and the arithmetic.
    t_cmd    cmd;
    t_status status;

    dlr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The output register inside the datapath lets a finished word wait for
    // the consumer while the controller returns to idle and takes the next word.
    dlr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

`default_nettype wire

// File: tb/sv/dimmer_level_ramp_unit_tb.sv
`timescale 1ns / 1ps

module dimmer_level_ramp_unit_tb;
    import dlr_pkg::*;

    localparam int          CLK_PERIOD  = 8;
    localparam int          RESET_TICKS = 6;
    // The dim command, which runs the divider, has the longest result latency; SETTLE covers it.
    localparam int          SETTLE      = 30;
    // Length of the long receiver hold-off that backs the block up into its input.
    localparam int unsigned LONG_HOLD   = 600;
    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int          NOISY_LINES = 40;

    // Kind codes that the block must ignore.
    localparam logic [2:0] KIND_SPARE_LO  = KIND_TOGGLE + 3'd1;
    localparam logic [2:0] KIND_SPARE_MID = KIND_SPARE_LO + 3'd1;
    localparam logic [2:0] KIND_SPARE_HI  = '1;

    // Every input of the block is known from time zero.
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [LVL_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    t_in_word             i_in_word  = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_word            o_out_word;

    dimmer_level_ramp_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Command words waiting to be offered, and result words predicted but not yet seen.
    t_in_word    cmd_backlog[$];
    t_out_word   ramp_words_due[$];
    t_out_word   want_word;

    // Idling controls: percent of cycles the sender holds back and the receiver stalls.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    logic        hold_go       = 1'b0;
    int unsigned hold_left     = 0;

    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    // Shadow copy of the configuration registers, at their reset values.
    logic             cfg_quad    = 1'b0;
    logic [LVL_W-1:0] cfg_step    = DIM_STEP_RST;
    logic [LVL_W-1:0] cfg_min     = '0;
    logic [LVL_W-1:0] cfg_max     = MAX_LVL_RST;
    logic             cfg_inhibit = 1'b0;

    // Shadow copy of the ramp state; everything clears on reset.
    logic [LVL_W-1:0] lvl_now     = '0;
    logic [LVL_W-1:0] lvl_goal    = '0;
    logic [DLY_W-1:0] delay_ticks = '0;
    logic [DLY_W-1:0] cnt_left    = '0;
    logic [LVL_W-1:0] drive_last  = '0;

    // Opening words: extremes of the level field, every command, both toggle
    // directions, saturation of the set command, dim moves and the spare kinds.
    t_in_word opening_cmds [22] = '{
        '{KIND_TICK,      8'h00},
        '{KIND_TOGGLE,    8'h00},
        '{KIND_TICK,      8'hFF},
        '{KIND_TICK,      8'h55},
        '{KIND_SET,       8'hFF},
        '{KIND_SET,       8'h80},
        '{KIND_SET,       8'h7F},
        '{KIND_TICK,      8'hAA},
        '{KIND_UP,        8'h00},
        '{KIND_TICK,      8'h00},
        '{KIND_TICK,      8'h00},
        '{KIND_DOWN,      8'hFF},
        '{KIND_TOGGLE,    8'hFF},
        '{KIND_SPARE_LO,  8'hFF},
        '{KIND_SPARE_MID, 8'h00},
        '{KIND_SPARE_HI,  8'hAA},
        '{KIND_SET,       8'h00},
        '{KIND_TICK,      8'h01},
        '{KIND_TICK,      8'h02},
        '{KIND_DOWN,      8'h00},
        '{KIND_UP,        8'hC8},
        '{KIND_TICK,      8'hC9}
    };

    function automatic int sat_full(input int v);
        return (v > FULL_LEVEL) ? FULL_LEVEL : v;
    endfunction

    // Advances the shadow ramp by one command word and returns the result
    // word that the block must produce for it.
    function automatic t_out_word step_ramp(input t_in_word w);
        t_out_word r;
        int        sq;
        r = '0;
        case (w.kind)
            KIND_TICK: begin
                // The countdown runs first; a step happens only once it is at zero.
                if (cnt_left != 0) cnt_left = cnt_left - 1'b1;
                if (lvl_now != lvl_goal && cnt_left == 0) begin
                    if (lvl_now < lvl_goal) lvl_now = lvl_now + 1'b1;
                    else lvl_now = lvl_now - 1'b1;
                    if (cfg_quad) begin
                        // Quadratic curve, never dark while the level is above zero.
                        sq = int'(lvl_now) * int'(lvl_now) / FULL_LEVEL;
                        if (lvl_now != 0 && sq == 0) sq = 1;
                        drive_last = LVL_W'(sq);
                    end else begin
                        drive_last = lvl_now;
                    end
                    cnt_left = delay_ticks;
                    r.drive_update = 1'b1;
                end
            end
            KIND_SET: begin
                // Inhibit never blocks a direct set.
                lvl_goal = LVL_W'(sat_full(int'(w.new_level)));
            end
            KIND_UP, KIND_DOWN, KIND_TOGGLE: begin
                if (cfg_inhibit) begin
                    r.rejected = 1'b1;
                end else if (w.kind == KIND_TOGGLE) begin
                    lvl_goal = (lvl_now != 0) ? '0 : FULL_L;
                end else begin
                    if (w.kind == KIND_UP) begin
                        if (int'(lvl_now) + int'(cfg_step) < int'(cfg_max))
                            lvl_goal = LVL_W'(sat_full(int'(lvl_now) + int'(cfg_step)));
                        else
                            lvl_goal = LVL_W'(sat_full(int'(cfg_max)));
                    end else begin
                        if (int'(lvl_now) > int'(cfg_min) + int'(cfg_step))
                            lvl_goal = LVL_W'(sat_full(int'(lvl_now) - int'(cfg_step)));
                        else
                            lvl_goal = LVL_W'(sat_full(int'(cfg_min)));
                    end
                    // A zero step falls back to the full base delay.
                    delay_ticks = (cfg_step == 0) ? STEP_BASE_D
                                                  : DLY_W'(STEP_BASE / int'(cfg_step));
                end
            end
            default: begin
            end
        endcase
        r.drive_level   = drive_last;
        r.current_level = lvl_now;
        r.target_level  = lvl_goal;
        return r;
    endfunction

    // Random command word. Ticks dominate so that the level actually travels
    // toward its target; the spare kinds show up now and then as noise.
    function automatic t_in_word random_cmd();
        t_in_word    w;
        int unsigned pick;
        pick        = $urandom_range(99);
        w.new_level = LVL_W'($urandom_range(255));
        if (pick < 55)      w.kind = KIND_TICK;
        else if (pick < 65) w.kind = KIND_SET;
        else if (pick < 77) w.kind = KIND_UP;
        else if (pick < 89) w.kind = KIND_DOWN;
        else if (pick < 96) w.kind = KIND_TOGGLE;
        else                w.kind = 3'(KIND_TOGGLE + $urandom_range(3, 1));
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= NOISY_LINES)
            $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // Waits until every command word has gone in and every result word has
    // come out, then lets the block settle. Sampled on the falling edge so the
    // decision never races the clocked processes.
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || i_in_valid || ramp_words_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // One phase of random traffic: drain, rewrite every register while the
    // block is idle, pick the idling mode, then queue the command words.
    task automatic run_phase(input logic quad, input logic [LVL_W-1:0] step,
                             input logic [LVL_W-1:0] lo, input logic [LVL_W-1:0] hi,
                             input logic inh, input int unsigned send_pct,
                             input int unsigned recv_pct, input int unsigned n_cmds,
                             input bit long_hold);
        logic [LVL_W-1:0] vals [5];
        int unsigned      n;
        vals = '{LVL_W'(quad), step, lo, hi, LVL_W'(inh)};
        n    = 0;
        wait_quiet();
        for (int k = 0; k <= int'(REG_INHIBIT); k++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(k);
            i_cfg_data <= vals[k];
        end
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        send_idle_pct <= send_pct;
        stall_pct     <= recv_pct;
        hold_go       <= long_hold;
        // The shadow registers follow the writes; nothing is in flight now.
        cfg_quad    = quad;
        cfg_step    = step;
        cfg_min     = lo;
        cfg_max     = hi;
        cfg_inhibit = inh;
        @(posedge i_clk);
        hold_go <= 1'b0;
        @(negedge i_clk);
        // Ignored spare kinds do not count toward the phase length.
        while (n < n_cmds) begin
            cmd_backlog.push_back(random_cmd());
            if (cmd_backlog[$].kind <= KIND_TOGGLE) n++;
        end
    endtask

    // Sender. A word stays on the bus, unchanged, until the block takes it.
    // The expectation is computed at the edge where the word is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                ramp_words_due.push_back(step_ramp(i_in_word));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_word  <= cmd_backlog.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off counter for the receiver, kicked by a one-cycle request.
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver. Each accepted result word is checked field by field against
    // the oldest prediction; stall is redrawn every cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (ramp_words_due.size() == 0) begin
                report_mismatch("result word with none pending",
                                int'(o_out_word.current_level), 0);
            end else begin
                want_word = ramp_words_due.pop_front();
                if (o_out_word.drive_level !== want_word.drive_level)
                    report_mismatch("drive_level", int'(o_out_word.drive_level),
                                    int'(want_word.drive_level));
                if (o_out_word.drive_update !== want_word.drive_update)
                    report_mismatch("drive_update", int'(o_out_word.drive_update),
                                    int'(want_word.drive_update));
                if (o_out_word.current_level !== want_word.current_level)
                    report_mismatch("current_level", int'(o_out_word.current_level),
                                    int'(want_word.current_level));
                if (o_out_word.target_level !== want_word.target_level)
                    report_mismatch("target_level", int'(o_out_word.target_level),
                                    int'(want_word.target_level));
                if (o_out_word.rejected !== want_word.rejected)
                    report_mismatch("rejected", int'(o_out_word.rejected),
                                    int'(want_word.rejected));
            end
        end
        i_out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening with the reset configuration and no idling.
        foreach (opening_cmds[k]) cmd_backlog.push_back(opening_cmds[k]);

        //        quad  step    min     max     inh   send recv  count hold
        // Defaults again, now with random words.
        run_phase(1'b0, 8'd5,   8'd0,   8'd200, 1'b0, 0,   0,   120,  1'b0);
        // Widest step: zero delay, so the level sweeps the whole range.
        run_phase(1'b1, 8'd200, 8'd0,   8'd200, 1'b0, 0,   0,   150,  1'b0);
        // Smallest nonzero step and inverted limits; sender mostly idle.
        run_phase(1'b0, 8'd1,   8'd200, 8'd0,   1'b0, 87,  0,   120,  1'b0);
        // Mid-range limits with the quadratic curve; receiver mostly stalled.
        run_phase(1'b1, 8'd37,  8'd20,  8'd180, 1'b0, 0,   87,  150,  1'b0);
        // Zero step and limits above full scale, so dim-down targets saturate.
        run_phase(1'b1, 8'd0,   8'd250, 8'd255, 1'b0, 38,  38,  100,  1'b0);
        // Inhibit set: dim and toggle words come back rejected.
        run_phase(1'b0, 8'd10,  8'd0,   8'd200, 1'b1, 38,  38,  100,  1'b0);
        // Receiver holds off for a long stretch while the sender keeps pushing.
        run_phase(1'b1, 8'd200, 8'd0,   8'd200, 1'b0, 0,   0,   150,  1'b1);
        run_phase(1'b0, 8'd100, 8'd50,  8'd150, 1'b0, 87,  0,   130,  1'b0);
        run_phase(1'b1, 8'd3,   8'd0,   8'd200, 1'b0, 0,   87,  130,  1'b0);

        wait_quiet();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: dimmer_level_ramp_unit.f
+incdir+rtl
rtl/dlr_pkg.sv
rtl/dlr_ctrl.sv
rtl/dlr_dp.sv
rtl/dimmer_level_ramp_unit.sv
tb/sv/dimmer_level_ramp_unit_tb.sv
